### rtl/dvfr_pkg.sv
// ----------------------------------------------------------------------------
// dvfr_pkg
// Shared constants and controller/datapath interface types of the decibel
// volume fade ramp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dvfr_pkg;

    localparam logic [16:0] MIN_FADE_MS = 17'd10;
    localparam logic [16:0] MAX_FADE_MS = 17'd100000;

    localparam logic signed [15:0] MIN_DB_RESET = -16'sd24576;

    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int  ADDR_W     = 3;
    localparam logic REG_MIN_DB = 1'b0;

    localparam logic MODE_SET  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct packed {
        logic load_item;
        logic load_prod;
        logic load_div;
        logic div_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic mid_fade;
    } status_t;

endpackage

`default_nettype wire

### rtl/dvfr_ctrl.sv
// ----------------------------------------------------------------------------
// dvfr_ctrl
// Sequencer of the fade ramp: request intake, multiply, serial divide and
// result hand-off; owns the result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dvfr_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    input  wire dvfr_pkg::status_t status,
    output dvfr_pkg::cmd_t        cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    localparam logic [dvfr_pkg::DIV_CNT_W-1:0] CNT_LAST =
        dvfr_pkg::DIV_CNT_W'(dvfr_pkg::DIV_STEPS - 1);

    logic [2:0]                     state_reg, state_next;
    logic [dvfr_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (status.mid_fade) begin
                    cmd.load_prod = 1'b1;
                    state_next    = ST_MUL;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_MUL: begin
                cmd.load_div = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.commit    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

### rtl/dvfr_datapath.sv
// ----------------------------------------------------------------------------
// dvfr_datapath
// Level and fade state, target clamp, 17x17 multiplier, restoring divider
// (one quotient bit per step) and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dvfr_datapath (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire dvfr_pkg::cmd_t    cmd,
    output dvfr_pkg::status_t      status,
    input  wire logic [55:0]       s_tdata,
    input  wire logic              s_tuser,
    input  wire logic              cfg_we,
    input  wire logic [15:0]       cfg_wdata,
    output logic [15:0]            min_db,
    output logic [15:0]            m_tdata,
    output logic [1:0]             m_tuser
);

    logic               mode_reg;
    logic signed [15:0] target_reg;
    logic [16:0]        fade_reg;
    logic [15:0]        delta_reg;

    logic signed [15:0] cur_reg, cur_next;
    logic signed [15:0] start_reg, start_next;
    logic signed [15:0] end_reg, end_next;
    logic [16:0]        len_reg, len_next;
    logic [16:0]        elap_reg, elap_next;
    logic               fading_reg, fading_next;
    logic signed [15:0] min_db_reg;

    logic [31:0] prod_reg;
    logic        neg_reg;
    logic [16:0] rem_reg;
    logic [15:0] lo_reg;
    logic [15:0] quo_reg;

    logic signed [15:0] out_level_reg;
    logic               out_upd_reg, out_upd_next;
    logic               out_act_reg;

    logic signed [15:0] floor_db;
    logic signed [15:0] tgt_clamp;
    logic               fade_ok;
    logic [17:0]        sum;
    logic               fade_end;
    logic signed [16:0] diff;
    logic [16:0]        mag;
    logic [33:0]        prod_full;
    logic [17:0]        trial;
    logic               trial_ge;
    logic [17:0]        trial_sub;
    logic signed [16:0] step17;
    logic signed [16:0] lvl17;

    assign floor_db  = min_db_reg[15] ? min_db_reg : 16'sd0;
    assign tgt_clamp = !target_reg[15] ? 16'sd0 :
                       (target_reg < floor_db) ? floor_db : target_reg;
    assign fade_ok   = (fade_reg > dvfr_pkg::MIN_FADE_MS) &&
                       (fade_reg < dvfr_pkg::MAX_FADE_MS);

    assign sum      = {1'b0, elap_reg} + {2'b00, delta_reg};
    assign fade_end = (sum >= {1'b0, len_reg});

    assign diff      = {end_reg[15], end_reg} - {start_reg[15], start_reg};
    assign mag       = diff[16] ? 17'(-diff) : 17'(diff);
    assign prod_full = mag * sum[16:0];

    assign trial     = {rem_reg, lo_reg[15]};
    assign trial_ge  = (trial >= {1'b0, len_reg});
    assign trial_sub = trial - {1'b0, len_reg};

    assign step17 = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign lvl17  = {start_reg[15], start_reg} + step17;

    assign status.mid_fade = (mode_reg == dvfr_pkg::MODE_TICK) && fading_reg && !fade_end;

    always_comb begin
        cur_next     = cur_reg;
        start_next   = start_reg;
        end_next     = end_reg;
        len_next     = len_reg;
        elap_next    = elap_reg;
        fading_next  = fading_reg;
        out_upd_next = 1'b0;
        if (mode_reg == dvfr_pkg::MODE_SET) begin
            if (fade_ok) begin
                len_next    = fade_reg;
                elap_next   = '0;
                start_next  = cur_reg;
                end_next    = tgt_clamp;
                fading_next = 1'b1;
            end else begin
                cur_next     = tgt_clamp;
                fading_next  = 1'b0;
                out_upd_next = 1'b1;
            end
        end else if (fading_reg) begin
            out_upd_next = 1'b1;
            if (fade_end) begin
                cur_next    = end_reg;
                len_next    = '0;
                elap_next   = '0;
                fading_next = 1'b0;
            end else begin
                elap_next = sum[16:0];
                cur_next  = lvl17[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg    <= '0;
            start_reg  <= '0;
            end_reg    <= '0;
            len_reg    <= '0;
            elap_reg   <= '0;
            fading_reg <= 1'b0;
            min_db_reg <= dvfr_pkg::MIN_DB_RESET;
        end else begin
            if (cfg_we) begin
                min_db_reg <= cfg_wdata;
            end
            if (cmd.commit) begin
                cur_reg    <= cur_next;
                start_reg  <= start_next;
                end_reg    <= end_next;
                len_reg    <= len_next;
                elap_reg   <= elap_next;
                fading_reg <= fading_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            mode_reg   <= s_tuser;
            target_reg <= s_tdata[15:0];
            fade_reg   <= s_tdata[32:16];
            delta_reg  <= s_tdata[48:33];
        end
        if (cmd.load_prod) begin
            prod_reg <= prod_full[31:0];
            neg_reg  <= diff[16];
        end
        if (cmd.load_div) begin
            rem_reg <= {1'b0, prod_reg[31:16]};
            lo_reg  <= prod_reg[15:0];
            quo_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= trial_ge ? trial_sub[16:0] : trial[16:0];
            lo_reg  <= {lo_reg[14:0], 1'b0};
            quo_reg <= {quo_reg[14:0], trial_ge};
        end
        if (cmd.commit) begin
            out_level_reg <= cur_next;
            out_upd_reg   <= out_upd_next;
            out_act_reg   <= fading_next;
        end
    end

    assign min_db  = min_db_reg;
    assign m_tdata = out_level_reg;
    assign m_tuser = {out_act_reg, out_upd_reg};

endmodule

`default_nettype wire

### rtl/decibel_volume_fade_ramp_unit.sv
// ----------------------------------------------------------------------------
// decibel_volume_fade_ramp_unit
// Volume level in Q7.8 dB, moved linearly to a target over a fade time.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests on s_*: s_tuser selects set (0) or tick (1); s_tdata
//   carries target_db, fade_ms and delta_ms. One result per request on m_*:
//   m_tdata is the level, m_tuser carries the update and fading flags.
//   min_db is written through the APB port at address 0.
// Sequencing:
//   One request at a time. A set, a tick outside a fade and the tick that
//   ends a fade pass through the decide and output states; a tick inside
//   a fade also passes through the multiply state and the 16-step serial
//   divider. The next request is taken the cycle after the result is loaded.
// Reset:
//   Level and fade state clear to zero, min_db returns to -24576 (-96 dB).
// Stall:
//   A pending result is held in the output register; a new request is
//   still taken, and its result waits until the register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module decibel_volume_fade_ramp_unit (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [55:0]                 s_tdata,  // target_db[15:0], fade_ms[32:16], delta_ms[48:33]
    input  wire logic                        s_tuser,  // mode
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [15:0]                      m_tdata,  // level_db[15:0]
    output logic [1:0]                       m_tuser,  // level_updated[0], fade_active[1]
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [dvfr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    dvfr_pkg::cmd_t    cmd;
    dvfr_pkg::status_t status;
    logic              cfg_we;
    logic [15:0]       min_db;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == dvfr_pkg::REG_MIN_DB);
    assign prdata = (paddr[2] == dvfr_pkg::REG_MIN_DB) ? {{16{min_db[15]}}, min_db} : 32'd0;

    dvfr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dvfr_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (pwdata[15:0]),
        .min_db    (min_db),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

### rtl/dvfr_checker.sv
// ----------------------------------------------------------------------------
// dvfr_checker
// Port-level checks of the fade ramp, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dvfr_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic [55:0]                 s_tdata,
    input wire logic                        s_tuser,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [15:0]                 m_tdata,
    input wire logic [1:0]                  m_tuser,
    input wire logic                        psel,
    input wire logic                        penable,
    input wire logic                        pwrite,
    input wire logic [dvfr_pkg::ADDR_W-1:0] paddr,
    input wire logic [31:0]                 pwdata,
    input wire logic [31:0]                 prdata,
    input wire logic                        pready
);

    a_level_not_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15] || (m_tdata == 16'd0)))
        else $error("level above 0 dB");

    a_one_request_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while busy");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind decibel_volume_fade_ramp_unit dvfr_checker u_checker (.*);

`default_nettype wire
